// ===== rtl/mots_pkg.sv =====
package mots_pkg;

  typedef enum logic [1:0] {
    OP_SET_UNACK = 2'd0,
    OP_SET_ACK   = 2'd1,
    OP_GET       = 2'd2,
    OP_TICK      = 2'd3
  } op_t;

  typedef enum logic {
    KIND_IND    = 1'b0,
    KIND_STATUS = 1'b1
  } kind_t;

  // Resolution codes of the transition time field.
  typedef enum logic [1:0] {
    RES_100MS = 2'd0,
    RES_1S    = 2'd1,
    RES_10S   = 2'd2,
    RES_10MIN = 2'd3
  } res_t;

  localparam logic [5:0]  FOREVER_STEPS     = 6'h3f;
  localparam logic [10:0] DELAY_MS_PER_STEP = 11'd5;
  localparam logic [19:0] MS_100MS          = 20'd100;
  localparam logic [19:0] MS_1S             = 20'd1000;
  localparam logic [19:0] MS_10S            = 20'd10000;
  localparam logic [19:0] MS_10MIN          = 20'd600000;
  // Neighboring resolutions differ by ten, except that ten minutes is sixty
  // ten-second steps.
  localparam logic [7:0]  RES_RATIO         = 8'd10;
  localparam logic [5:0]  FINE_STEPS_MAX    = 6'd6;
  localparam logic [7:0]  TEN_MIN_IN_10S    = 8'd60;

  typedef struct packed {
    op_t         operation;
    logic [7:0]  on_off_byte;
    logic [7:0]  transaction_id;
    logic [15:0] source_address;
    logic        has_timing;
    logic [7:0]  transition_code;
    logic [7:0]  delay_steps;
    logic        app_present;
  } item_t;

  typedef struct packed {
    kind_t      kind;
    logic       on_off;
    logic [7:0] total_code;
    logic [7:0] remaining_code;
    logic       present;
    logic       target;
    logic       has_remaining;
    logic       last;
  } res_t_pkt_t;

  // Up to two results that one item produces, in delivery order.
  typedef struct packed {
    logic [1:0] count;
    res_t_pkt_t first;
    res_t_pkt_t second;
  } push_t;

endpackage

// ===== rtl/mots_engine.sv =====
module mots_engine (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              item_valid,
  input  mots_pkg::item_t   item,
  output mots_pkg::push_t   push
);

  logic        sv_r, sv_nxt;
  logic [7:0]  last_tid_r, last_tid_nxt;
  logic [15:0] last_src_r, last_src_nxt;
  logic [5:0]  tsteps_r, tsteps_nxt;
  logic [1:0]  tres_r, tres_nxt;
  logic        tfor_r, tfor_nxt;
  logic [10:0] dleft_r, dleft_nxt;
  logic        darm_r, darm_nxt;
  logic [25:0] tleft_r, tleft_nxt;
  logic        tarm_r, tarm_nxt;

  logic        set_op;
  logic        dup;
  logic [5:0]  set_steps;
  logic [1:0]  set_res;
  logic        set_for;
  logic [10:0] set_delay;
  logic        bc;
  logic        fresh;
  logic        bc_tnz;
  logic [7:0]  bc_code;
  logic [25:0] bc_ms;
  logic        st_tnz;
  logic [1:0]  n;
  mots_pkg::res_t_pkt_t rs [2];

  function automatic logic [19:0] res_ms(input logic [1:0] res);
    logic [19:0] ms;
    case (mots_pkg::res_t'(res))
      mots_pkg::RES_100MS: ms = mots_pkg::MS_100MS;
      mots_pkg::RES_1S:    ms = mots_pkg::MS_1S;
      mots_pkg::RES_10S:   ms = mots_pkg::MS_10S;
      mots_pkg::RES_10MIN: ms = mots_pkg::MS_10MIN;
      default:             ms = mots_pkg::MS_100MS;
    endcase
    return ms;
  endfunction

  // The stored time is always a whole number of steps at its own resolution,
  // so re-encoding at the finest resolution that fits is a small exact
  // rescale and needs no division.
  function automatic logic [7:0] encode(input logic forever_t, input logic [5:0] steps,
                                        input logic [1:0] res);
    logic [7:0] code;
    if (forever_t) begin
      code = {2'b00, mots_pkg::FOREVER_STEPS};
    end else begin
      case (mots_pkg::res_t'(res))
        mots_pkg::RES_100MS: code = {2'b00, steps};
        mots_pkg::RES_1S: begin
          if (steps <= mots_pkg::FINE_STEPS_MAX) begin
            code = 8'(8'(steps) * mots_pkg::RES_RATIO);
          end else begin
            code = {mots_pkg::RES_1S, steps};
          end
        end
        mots_pkg::RES_10S: begin
          if (steps == 6'd0) begin
            code = 8'd0;
          end else if (steps <= mots_pkg::FINE_STEPS_MAX) begin
            code = {mots_pkg::RES_1S, 6'(8'(steps) * mots_pkg::RES_RATIO)};
          end else begin
            code = {mots_pkg::RES_10S, steps};
          end
        end
        mots_pkg::RES_10MIN: begin
          if (steps == 6'd0) begin
            code = 8'd0;
          end else if (steps == 6'd1) begin
            code = {mots_pkg::RES_10S, mots_pkg::TEN_MIN_IN_10S[5:0]};
          end else begin
            code = {mots_pkg::RES_10MIN, steps};
          end
        end
        default: code = 8'd0;
      endcase
    end
    return code;
  endfunction

  function automatic mots_pkg::res_t_pkt_t make_ind(input logic on, input logic [7:0] total,
                                                    input logic [7:0] remain);
    mots_pkg::res_t_pkt_t r;
    r                = '0;
    r.kind           = mots_pkg::KIND_IND;
    r.on_off         = on;
    r.total_code     = total;
    r.remaining_code = remain;
    return r;
  endfunction

  always_comb begin
    sv_nxt       = sv_r;
    last_tid_nxt = last_tid_r;
    last_src_nxt = last_src_r;
    tsteps_nxt   = tsteps_r;
    tres_nxt     = tres_r;
    tfor_nxt     = tfor_r;
    dleft_nxt    = dleft_r;
    darm_nxt     = darm_r;
    tleft_nxt    = tleft_r;
    tarm_nxt     = tarm_r;
    rs[0]        = '0;
    rs[1]        = '0;
    n            = 2'd0;
    bc           = 1'b0;
    fresh        = 1'b0;

    set_op = (item.operation == mots_pkg::OP_SET_UNACK) ||
             (item.operation == mots_pkg::OP_SET_ACK);
    if (item.has_timing) begin
      set_steps = item.transition_code[5:0];
      set_res   = item.transition_code[7:6];
      set_delay = 11'(item.delay_steps) * mots_pkg::DELAY_MS_PER_STEP;
    end else begin
      set_steps = 6'd0;
      set_res   = 2'd0;
      set_delay = 11'd0;
    end
    set_for = item.has_timing && (set_steps == mots_pkg::FOREVER_STEPS);
    dup     = (item.transaction_id == last_tid_r) && (item.source_address == last_src_r);

    if (set_op && !dup) begin
      last_tid_nxt = item.transaction_id;
      last_src_nxt = item.source_address;
      sv_nxt       = |item.on_off_byte;
      tsteps_nxt   = set_for ? 6'd0 : set_steps;
      tres_nxt     = set_res;
      tfor_nxt     = set_for;
      if (set_delay == 11'd0) begin
        bc = 1'b1;
      end else begin
        darm_nxt  = 1'b1;
        dleft_nxt = set_delay;
      end
    end

    // Delay countdown runs before the transition countdown on a tick.
    if ((item.operation == mots_pkg::OP_TICK) && darm_r) begin
      if (dleft_r <= 11'd1) begin
        dleft_nxt = 11'd0;
        darm_nxt  = 1'b0;
        bc        = 1'b1;
        fresh     = tfor_r || (tsteps_r != 6'd0);
      end else begin
        dleft_nxt = dleft_r - 11'd1;
      end
    end

    bc_tnz  = tfor_nxt || (tsteps_nxt != 6'd0);
    bc_code = encode(tfor_nxt, tsteps_nxt, tres_nxt);
    bc_ms   = 26'(tsteps_nxt) * 26'(res_ms(tres_nxt));
    if (bc) begin
      if (bc_tnz) begin
        if (sv_nxt) begin
          rs[n[0]] = make_ind(sv_nxt, bc_code, bc_code);
          n        = n + 2'd1;
        end
        tarm_nxt  = 1'b1;
        tleft_nxt = bc_ms;
      end else begin
        rs[n[0]] = make_ind(sv_nxt, 8'd0, 8'd0);
        n        = n + 2'd1;
      end
    end

    // A transition armed by this same tick starts counting on the next one.
    if ((item.operation == mots_pkg::OP_TICK) && tarm_r && !fresh && !tfor_r) begin
      if (tleft_r <= 26'd1) begin
        tleft_nxt  = 26'd0;
        tarm_nxt   = 1'b0;
        if (!sv_r) begin
          rs[n[0]] = make_ind(1'b0, 8'd0, 8'd0);
          n        = n + 2'd1;
        end
        tsteps_nxt = 6'd0;
        tfor_nxt   = 1'b0;
      end else begin
        tleft_nxt = tleft_r - 26'd1;
      end
    end

    st_tnz = tfor_nxt || (tsteps_nxt != 6'd0);
    if ((item.operation == mots_pkg::OP_SET_ACK) || (item.operation == mots_pkg::OP_GET)) begin
      rs[n[0]]         = '0;
      rs[n[0]].kind    = mots_pkg::KIND_STATUS;
      rs[n[0]].present = item.app_present;
      if (st_tnz) begin
        rs[n[0]].remaining_code = encode(tfor_nxt, tsteps_nxt, tres_nxt);
        rs[n[0]].target         = sv_nxt;
        rs[n[0]].has_remaining  = 1'b1;
      end
      n = n + 2'd1;
    end

    if (n == 2'd1) begin
      rs[0].last = 1'b1;
    end else if (n == 2'd2) begin
      rs[1].last = 1'b1;
    end
  end

  assign push.count  = item_valid ? n : 2'd0;
  assign push.first  = rs[0];
  assign push.second = rs[1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sv_r       <= 1'b0;
      last_tid_r <= 8'd0;
      last_src_r <= 16'd0;
      tsteps_r   <= 6'd0;
      tres_r     <= 2'd0;
      tfor_r     <= 1'b0;
      dleft_r    <= 11'd0;
      darm_r     <= 1'b0;
      tleft_r    <= 26'd0;
      tarm_r     <= 1'b0;
    end else if (item_valid) begin
      sv_r       <= sv_nxt;
      last_tid_r <= last_tid_nxt;
      last_src_r <= last_src_nxt;
      tsteps_r   <= tsteps_nxt;
      tres_r     <= tres_nxt;
      tfor_r     <= tfor_nxt;
      dleft_r    <= dleft_nxt;
      darm_r     <= darm_nxt;
      tleft_r    <= tleft_nxt;
      tarm_r     <= tarm_nxt;
    end
  end

  a_delay_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    darm_r |-> (dleft_r != 11'd0))
    else $error("armed delay countdown holds zero");

  a_forever_no_steps: assert property (@(posedge clk) disable iff (!rst_n)
    tfor_r |-> (tsteps_r == 6'd0))
    else $error("forever transition with nonzero step count");

  a_get_one_status: assert property (@(posedge clk) disable iff (!rst_n)
    (item_valid && (item.operation == mots_pkg::OP_GET)) |->
      ((push.count == 2'd1) && (push.first.kind == mots_pkg::KIND_STATUS) &&
       push.first.last))
    else $error("get did not produce exactly one final status");

endmodule

// ===== rtl/mots_res_fifo.sv =====
module mots_res_fifo #(
  parameter int DEPTH = 8
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  mots_pkg::push_t                push,
  input  logic                           pop,
  output logic                           head_valid,
  output mots_pkg::res_t_pkt_t           head,
  output logic [$clog2(DEPTH+1)-1:0]     count
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  mots_pkg::res_t_pkt_t mem_r [DEPTH];
  logic [AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [AW-1:0] wr_ptr_p1;
  logic [CW-1:0] cnt_r, cnt_nxt;

  function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
    return (p == AW'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  always_comb begin
    wr_ptr_p1  = ptr_inc(wr_ptr_r);
    wr_ptr_nxt = wr_ptr_r;
    if (push.count == 2'd1) begin
      wr_ptr_nxt = wr_ptr_p1;
    end else if (push.count == 2'd2) begin
      wr_ptr_nxt = ptr_inc(wr_ptr_p1);
    end
    rd_ptr_nxt = pop ? ptr_inc(rd_ptr_r) : rd_ptr_r;
    cnt_nxt    = cnt_r + CW'(push.count) - CW'(pop);
  end

  always_ff @(posedge clk) begin
    if (push.count != 2'd0) begin
      mem_r[wr_ptr_r] <= push.first;
    end
    if (push.count == 2'd2) begin
      mem_r[wr_ptr_p1] <= push.second;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  assign head_valid = (cnt_r != '0);
  assign head       = mem_r[rd_ptr_r];
  assign count      = cnt_r;

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    ((CW + 2)'(cnt_r) + (CW + 2)'(push.count)) <= ((CW + 2)'(DEPTH) + (CW + 2)'(pop)))
    else $error("result queue overflow");

endmodule

// ===== rtl/mesh_onoff_server_timing_core.sv =====
// On/off server with delay and transition timing. Items arrive on the in_
// stream with the operation in in_tuser (set unacknowledged, set acknowledged,
// get, one-millisecond tick); each produces zero, one or two result beats on
// the out_ stream (application indications with out_tuser low, status replies
// with out_tuser high), and out_tlast marks the last beat caused by an item.
// An accepted item is registered, evaluated against the server state in the
// next cycle, and its results are queued for out_. One item is taken per cycle
// while in_tready is high and results drain at one per cycle while out_tready
// is high, so the sustained rate is bounded by the single-beat output port: an
// item with two results needs two output beats. in_tready drops only when the
// result queue (RESULT_DEPTH entries), with two entries held back for an item
// waiting in the input register, has fewer than two free entries.
module mesh_onoff_server_timing_core #(
  parameter int RESULT_DEPTH = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // on_off_byte[7:0], transaction_id[15:8], source_address[31:16],
  // has_timing[32], transition_code[40:33], delay_steps[48:41],
  // app_present[49], zero fill above
  input  logic [55:0] in_tdata,
  // operation[1:0]
  input  logic [1:0]  in_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  // on_off[0], total_code[8:1], remaining_code[16:9], present[17],
  // target[18], has_remaining[19], zero fill above
  output logic [23:0] out_tdata,
  // kind[0]
  output logic        out_tuser,
  output logic        out_tlast
);

  localparam int CW = $clog2(RESULT_DEPTH + 1);

  mots_pkg::item_t      item_in;
  mots_pkg::item_t      s1_item_r;
  logic                 s1_valid_r;
  mots_pkg::push_t      push;
  mots_pkg::res_t_pkt_t head;
  logic [CW-1:0]        fifo_cnt;
  logic                 in_beat;
  logic                 out_beat;

  assign item_in.operation       = mots_pkg::op_t'(in_tuser);
  assign item_in.on_off_byte     = in_tdata[7:0];
  assign item_in.transaction_id  = in_tdata[15:8];
  assign item_in.source_address  = in_tdata[31:16];
  assign item_in.has_timing      = in_tdata[32];
  assign item_in.transition_code = in_tdata[40:33];
  assign item_in.delay_steps     = in_tdata[48:41];
  assign item_in.app_present     = in_tdata[49];

  // Leave room for the item in the input register and the one about to enter,
  // two beats each at most.
  assign in_tready = ((CW + 1)'(fifo_cnt) + (s1_valid_r ? (CW + 1)'(2) : (CW + 1)'(0)))
                     <= (CW + 1)'(RESULT_DEPTH - 2);
  assign in_beat   = in_tvalid && in_tready;
  assign out_beat  = out_tvalid && out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= in_beat;
    end
  end

  always_ff @(posedge clk) begin
    if (in_beat) begin
      s1_item_r <= item_in;
    end
  end

  mots_engine u_engine (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_valid (s1_valid_r),
    .item       (s1_item_r),
    .push       (push)
  );

  mots_res_fifo #(
    .DEPTH (RESULT_DEPTH)
  ) u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .pop        (out_beat),
    .head_valid (out_tvalid),
    .head       (head),
    .count      (fifo_cnt)
  );

  assign out_tdata = {4'b0000, head.has_remaining, head.target, head.present,
                      head.remaining_code, head.total_code, head.on_off};
  assign out_tuser = 1'(head.kind);
  assign out_tlast = head.last;

  a_room_for_item: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r |-> ((CW + 1)'(fifo_cnt) <= (CW + 1)'(RESULT_DEPTH - 2)))
    else $error("registered item has no room in the result queue");

endmodule
